/* rtl/core/midi_note_keymap_packer_unit_defines.svh */
// Assertion macros shared by the keymap packer checker.
`ifndef MIDI_NOTE_KEYMAP_PACKER_UNIT_DEFINES_SVH
`define MIDI_NOTE_KEYMAP_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MNKP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keymap packer check failed");

// Next-cycle implication, disabled during reset.
`define MNKP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keymap packer check failed");

`endif

/* rtl/core/mnkp_pkg.sv */
// Package with the shared types and constants of the keymap packer.
package mnkp_pkg;

   localparam int SLOT_MAX_W = 7;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

   typedef enum logic [1:0] {
      ARM_NONE  = 2'd0,
      ARM_SET   = 2'd1,
      ARM_CLEAR = 2'd2
   } arm_type;

   typedef enum logic [1:0] {
      OP_NOP   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EMIT = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type                op;
      logic [SLOT_MAX_W-1:0] slot;
      logic                  emit;
   } cmd_type;

endpackage

/* rtl/core/mnkp_front.sv */
// Front end: decodes MIDI bytes into key update and map output commands.
module mnkp_front
   import mnkp_pkg::*;
#(
   parameter int FIRST_KEY = 21,
   parameter int OUT_BYTES = 11
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       queue_full,
   output logic       cmd_push,
   output cmd_type    cmd_out
);

   localparam int MAP_KEYS = OUT_BYTES * 8;

   arm_type    arm_ff;
   arm_type    arm_in;
   logic       accept;
   logic [7:0] key_ext;
   logic [7:0] key_diff;
   logic       in_range;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign key_ext    = {1'b0, req_tdata[6:0]};
   assign key_diff   = key_ext - 8'(FIRST_KEY);
   assign in_range   = (key_ext >= 8'(FIRST_KEY)) && (key_diff < 8'(MAP_KEYS));

   always_comb begin
      arm_in = arm_ff;
      if (accept) begin
         if (req_tdata[7]) begin
            if (req_tdata[7:4] == NIB_NOTE_ON) begin
               arm_in = ARM_SET;
            end else if (req_tdata[7:4] == NIB_NOTE_OFF) begin
               arm_in = ARM_CLEAR;
            end else begin
               arm_in = ARM_NONE;
            end
         end else begin
            arm_in = ARM_NONE;
         end
      end
   end

   always_comb begin
      cmd_out.op   = OP_NOP;
      cmd_out.slot = key_diff[SLOT_MAX_W-1:0];
      cmd_out.emit = req_tlast;
      if (!req_tdata[7] && in_range) begin
         unique case (arm_ff)
            ARM_SET:   cmd_out.op = OP_SET;
            ARM_CLEAR: cmd_out.op = OP_CLEAR;
            default:   cmd_out.op = OP_NOP;
         endcase
      end
      cmd_push = accept && ((cmd_out.op != OP_NOP) || cmd_out.emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff <= ARM_NONE;
      end else begin
         arm_ff <= arm_in;
      end
   end

endmodule

/* rtl/core/mnkp_queue.sv */
// Two-entry command queue between the decoder and the map engine.
module mnkp_queue
   import mnkp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_data
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/mnkp_back.sv */
// Back end: holds the key map, applies updates and streams the packed map.
module mnkp_back
   import mnkp_pkg::*;
#(
   parameter int OUT_BYTES = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd_in,
   output logic        cmd_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int GRP_W  = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
   localparam int SLOT_W = GRP_W + 3;
   localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(OUT_BYTES - 1);

   back_state_type   state_ff;
   back_state_type   state_in;
   logic [7:0]       map_ff [OUT_BYTES];
   logic [GRP_W-1:0] grp_ff;
   logic [GRP_W-1:0] grp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       led_ff;
   logic [3:0]       index_ff;
   logic             last_ff;
   logic             load;
   logic [GRP_W-1:0] wr_grp;
   logic [2:0]       wr_bit;

   assign wr_grp = cmd_in.slot[SLOT_W-1:3];
   assign wr_bit = ~cmd_in.slot[2:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd_in.emit) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (load && (grp_ff == LAST_GRP)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      load         = (state_ff == BK_EMIT) && (!rsp_valid_ff || rsp_tready);
      cmd_pop      = (state_ff == BK_IDLE) && cmd_valid;
      grp_in       = grp_ff;
      if (state_ff == BK_IDLE) begin
         grp_in = '0;
      end else if (load) begin
         grp_in = grp_ff + GRP_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < OUT_BYTES; g++) begin
            map_ff[g] <= 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_pop) begin
            if (cmd_in.op == OP_SET) begin
               map_ff[wr_grp][wr_bit] <= 1'b1;
            end else if (cmd_in.op == OP_CLEAR) begin
               map_ff[wr_grp][wr_bit] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         led_ff   <= map_ff[grp_ff];
         index_ff <= 4'(grp_ff);
         last_ff  <= (grp_ff == LAST_GRP);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, index_ff, led_ff};
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/core/midi_note_keymap_packer_unit.sv */
// Top level of the MIDI note keymap packer.
//
// The req channel takes one MIDI byte per transaction in req_tdata, with
// req_tlast marking the byte that ends a message. Note-on and note-off
// status bytes arm a set or a clear; the next data byte names the key.
// When a byte with req_tlast is taken, the rsp channel returns the key map
// as OUT_BYTES transactions, one group of eight keys each, lowest key in
// bit 7 of group 0, with rsp_tlast on the final group.
// A byte is decoded in the cycle it is taken and lands in a two-entry queue.
// The map engine pops one command per cycle while it is idle, so bytes
// without req_tlast flow at one per cycle while no map dump is in progress.
// A map dump holds its engine while it takes the command and then loads
// each byte in turn into the output register, lowest group first.
// A stalled rsp channel holds the map engine; the queue then fills and
// req_tready drops. Reset clears the map, the armed note action, the
// queue and any pending response.
module midi_note_keymap_packer_unit
   import mnkp_pkg::*;
#(
   parameter int FIRST_KEY = 21,
   parameter int OUT_BYTES = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] midi_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [7:0] led_byte, [11:8] byte_index, [15:12] zero
   output logic        rsp_tlast
);

   logic    queue_full;
   logic    cmd_push;
   cmd_type push_cmd;
   logic    cmd_pop;
   logic    cmd_valid;
   cmd_type pop_cmd;

   mnkp_front #(
      .FIRST_KEY (FIRST_KEY),
      .OUT_BYTES (OUT_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd_out    (push_cmd)
   );

   mnkp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_data  (pop_cmd)
   );

   mnkp_back #(
      .OUT_BYTES (OUT_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_in     (pop_cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/core/mnkp_checker.sv */
// Port-level checker for the keymap packer and its bind statement.
`include "midi_note_keymap_packer_unit_defines.svh"

module mnkp_checker #(
   parameter int OUT_BYTES = 11
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   `MNKP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `MNKP_ASSERT_NOW(a_index_range, clock, reset, rsp_tvalid, {1'b0, rsp_tdata[11:8]} < 5'(OUT_BYTES))
   `MNKP_ASSERT_NOW(a_last_index, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[11:8] == 4'(OUT_BYTES - 1)))
   `MNKP_ASSERT_NEXT(a_index_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tdata[11:8] == $past(rsp_tdata[11:8]) + 4'd1))

endmodule

bind midi_note_keymap_packer_unit mnkp_checker #(
   .OUT_BYTES (OUT_BYTES)
) u_mnkp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
